@@ hw/rtl/mhpq_pkg.sv @@
`default_nettype none

package mhpq_pkg;

  // Operation codes carried on s_tuser
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_DN_LOAD,
    ST_DN_CHK,
    ST_DN_LEFT,
    ST_DN_RIGHT,
    ST_DN_CMP,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/mhpq_ram.sv @@
`default_nettype none

module mhpq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/max_heap_priority_queue.sv @@
`default_nettype none

// Binary max-heap priority queue. Each input item either inserts a key with
// its payload (s_tuser = 0) or deletes the largest entry (s_tuser = 1); every
// item gives one result with the root entry, the entry count and a status
// (0 done, 1 insert rejected because full, 2 delete ignored because empty).
// Entries sit in one single-port-write, registered-read RAM in level order,
// and a small sequencer walks the tree with one shared key comparator.
// s_tready is high only while the sequencer is idle. An insert climbs the
// tree level by level and a delete descends it level by level, reading the
// right child only where the node has one; a rejected or ignored item goes
// straight to the result. Each step of the walk waits on the RAM's registered
// read. s_tready returns with m_tvalid, so the next item is not accepted
// before the finished result is in the output register, where it waits; a
// result still waiting there when the next one is done holds the sequencer
// until m_tready takes it.
module max_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int CAPACITY     = 1024,
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 16,
  localparam int CNT_W       = $clog2(CAPACITY + 1),
  localparam int IN_W        = ((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
  localparam int OUT_W       = ((KEY_BITS + PAYLOAD_BITS + CNT_W + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // key_value, payload_value
  input  wire logic             s_tuser,   // opcode
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [OUT_W-1:0] m_tdata,   // top_key, top_payload, entry_count
  output logic      [2:0]       m_tuser    // is_empty, status[1:0]
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int IDX_W  = ADDR_W + 2;
  localparam int ENT_W  = KEY_BITS + PAYLOAD_BITS;

  state_t state, state_next;

  logic [CNT_W-1:0]        count;
  logic [ADDR_W-1:0]       pos;
  logic [KEY_BITS-1:0]     ent_key;
  logic [PAYLOAD_BITS-1:0] ent_pay;
  logic [KEY_BITS-1:0]     child_key;
  logic [PAYLOAD_BITS-1:0] child_pay;
  logic                    pick_right;
  status_t                 status;
  logic [KEY_BITS-1:0]     root_key;
  logic [PAYLOAD_BITS-1:0] root_pay;

  logic [KEY_BITS-1:0]     out_key;
  logic [PAYLOAD_BITS-1:0] out_pay;
  logic [CNT_W-1:0]        out_count;
  status_t                 out_status;

  // RAM port
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ENT_W-1:0]  wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ENT_W-1:0]  rd_data;

  logic [KEY_BITS-1:0]     rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic [KEY_BITS-1:0]     in_key;
  logic [PAYLOAD_BITS-1:0] in_pay;

  logic [ADDR_W-1:0] pos_m1;
  logic [ADDR_W-1:0] parent;
  logic [CNT_W-1:0]  cnt_m1;
  logic [IDX_W-1:0]  left_idx;
  logic [IDX_W-1:0]  right_idx;
  logic [IDX_W-1:0]  count_ext;
  logic              has_left;
  logic              has_right;
  logic              full;

  // Shared comparator
  logic [KEY_BITS-1:0] cmp_a;
  logic [KEY_BITS-1:0] cmp_b;
  logic                lt;

  logic accept;
  logic out_free;

  assign in_key = s_tdata[KEY_BITS-1:0];
  assign in_pay = s_tdata[ENT_W-1:KEY_BITS];
  assign rd_key = rd_data[KEY_BITS-1:0];
  assign rd_pay = rd_data[ENT_W-1:KEY_BITS];

  assign pos_m1    = pos - 1'b1;
  assign parent    = ADDR_W'(pos_m1 >> 1);
  assign cnt_m1    = count - 1'b1;
  assign left_idx  = {1'b0, pos, 1'b1};
  assign right_idx = left_idx + 1'b1;
  assign count_ext = IDX_W'(count);
  assign has_left  = left_idx < count_ext;
  assign has_right = right_idx < count_ext;
  assign full      = count == CNT_W'(CAPACITY);

  assign lt = cmp_a < cmp_b;

  assign s_tready = state == ST_IDLE;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  mhpq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == OP_INSERT) begin
            state_next = full ? ST_FINISH : ST_UP_CHK;
          end else begin
            state_next = (count == '0) ? ST_FINISH : ST_DN_LOAD;
          end
        end
      end
      ST_UP_CHK:   state_next = (pos == '0) ? ST_FINISH : ST_UP_CMP;
      ST_UP_CMP:   state_next = lt ? ST_UP_CHK : ST_FINISH;
      ST_DN_LOAD:  state_next = (count == '0) ? ST_FINISH : ST_DN_CHK;
      ST_DN_CHK:   state_next = has_left ? ST_DN_LEFT : ST_FINISH;
      ST_DN_LEFT:  state_next = has_right ? ST_DN_RIGHT : ST_DN_CMP;
      ST_DN_RIGHT: state_next = ST_DN_CMP;
      ST_DN_CMP:   state_next = lt ? ST_DN_CHK : ST_FINISH;
      ST_FINISH:   state_next = out_free ? ST_IDLE : ST_FINISH;
      default:     state_next = ST_IDLE;
    endcase
  end

  // RAM and comparator control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = {ent_pay, ent_key};
    rd_addr = parent;
    cmp_a   = rd_key;
    cmp_b   = ent_key;
    case (state)
      ST_IDLE: begin
        rd_addr = cnt_m1[ADDR_W-1:0];
      end
      ST_UP_CHK: begin
        // root reached: drop the entry here
        wr_en = pos == '0;
      end
      ST_UP_CMP: begin
        // parent smaller: move it down, else settle the entry
        wr_en = 1'b1;
        if (lt) begin
          wr_data = rd_data;
        end
      end
      ST_DN_CHK: begin
        wr_en   = !has_left;
        rd_addr = left_idx[ADDR_W-1:0];
      end
      ST_DN_LEFT: begin
        rd_addr = right_idx[ADDR_W-1:0];
      end
      ST_DN_RIGHT: begin
        cmp_a = child_key;
        cmp_b = rd_key;
      end
      ST_DN_CMP: begin
        cmp_a = ent_key;
        cmp_b = child_key;
        wr_en = 1'b1;
        if (lt) begin
          wr_data = {child_pay, child_key};
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && accept) begin
        if (s_tuser == OP_INSERT && !full) begin
          count <= count + 1'b1;
        end else if (s_tuser == OP_DELETE && count != '0) begin
          count <= cnt_m1;
        end
      end
      if (state == ST_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (wr_en && wr_addr == '0) begin
      root_key <= wr_data[KEY_BITS-1:0];
      root_pay <= wr_data[ENT_W-1:KEY_BITS];
    end
    case (state)
      ST_IDLE: begin
        if (accept) begin
          ent_key <= in_key;
          ent_pay <= in_pay;
          pos     <= (s_tuser == OP_INSERT) ? count[ADDR_W-1:0] : '0;
          if (s_tuser == OP_INSERT) begin
            status <= full ? STAT_FULL : STAT_DONE;
          end else begin
            status <= (count == '0) ? STAT_EMPTY : STAT_DONE;
          end
        end
      end
      ST_UP_CMP: begin
        if (lt) begin
          pos <= parent;
        end
      end
      ST_DN_LOAD: begin
        ent_key <= rd_key;
        ent_pay <= rd_pay;
      end
      ST_DN_LEFT: begin
        child_key  <= rd_key;
        child_pay  <= rd_pay;
        pick_right <= 1'b0;
      end
      ST_DN_RIGHT: begin
        // take the right child only when strictly larger
        if (lt) begin
          child_key  <= rd_key;
          child_pay  <= rd_pay;
          pick_right <= 1'b1;
        end
      end
      ST_DN_CMP: begin
        if (lt) begin
          pos <= pick_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_key    <= (count == '0) ? '0 : root_key;
          out_pay    <= (count == '0) ? '0 : root_pay;
          out_count  <= count;
          out_status <= status;
        end
      end
      default: begin
        pos <= pos;
      end
    endcase
  end

  assign m_tdata = OUT_W'({out_count, out_pay, out_key});
  assign m_tuser = {out_status, out_count == '0};

endmodule

`default_nettype wire
